FILE: src/nearest_sample_rate_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-sample rate converter
// Clocked property checks that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SAMPLE_RATE_CONVERTER_ASSERT_SVH
`define NEAREST_SAMPLE_RATE_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
`define NSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define NSRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/nsrc_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-sample rate converter package
// Widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package nsrc_pkg;

  localparam int RATE_W = 18;
  localparam int POS_W  = 18;
  localparam int DIVD_W = POS_W + RATE_W;

  localparam int FRAME_BITS_DEF = 32;
  localparam int MAX_RUN_DEF    = 64;

  localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd44100;
  localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_EVAL,
    S_EMIT,
    S_WRAP
  } state_e;

endpackage

FILE: src/nsrc_div.sv
// ----------------------------------------------------------------------------
// Nearest-sample rate converter divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module nsrc_div
  import nsrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] div_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [RATE_W:0]   shifted;
  logic [RATE_W:0]   diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVD_W-2:0], ge};
      rem_d = ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/nearest_sample_rate_converter.sv
// ----------------------------------------------------------------------------
// Nearest-sample rate converter
// Zero-order-hold rate conversion: each input frame is repeated for every
// output position that maps onto it.
// ----------------------------------------------------------------------------
// Usage: push frames on in_valid_i/in_ready_o; copies come out on
// out_valid_o/out_ready_i with last_o on the final copy of a frame and
// clipped_o on every copy of a frame whose run exceeded MAX_RUN positions.
// A frame may produce no copy at all.
// Rates are written on cfg_valid_i/cfg_ready_o (index 0 in_rate, 1 out_rate)
// while the block is idle; writing in_rate clears both position counters.
// Sequence: when the rates differ, a frame passes an accept, a multiply and
// a divider start state, waits on the 36-step restoring divider, then goes
// through evaluate, any emitted copies and counter-wrap; with equal rates it
// goes from accept straight to one emitted copy and the counter wrap.
// in_ready_o is high only between frames and while no configuration write
// is offered. Copies are shown one per cycle from registered state while
// out_ready_i is high; a stall holds the current copy and the sequencer.
// Reset: rates return to 44100 and 48000, counters clear, no item pending.
// ----------------------------------------------------------------------------
`include "nearest_sample_rate_converter_assert.svh"

module nearest_sample_rate_converter
  import nsrc_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [RATE_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FRAME_BITS-1:0] in_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAME_BITS-1:0] out_frame_o,
  output logic                  last_o,
  output logic                  clipped_o
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  state_e state_q, state_d;

  logic [RATE_W-1:0]     in_rate_q, out_rate_q;
  logic [POS_W-1:0]      in_pos_q, out_pos_q;
  logic [POS_W-1:0]      opos_q;
  logic [RUN_W-1:0]      emit_q, cnt_q;
  logic                  clip_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [DIVD_W-1:0]     prod_q;

  logic [RATE_W-1:0]     ir_eff, or_eff;
  logic                  rates_eq;
  logic                  in_acc, out_acc, cfg_acc;
  logic                  div_start, div_done;
  logic [DIVD_W-1:0]     quotient;
  logic [DIVD_W-1:0]     dividend;
  logic [POS_W:0]        ipos1;
  logic [DIVD_W-1:0]     prod_full;
  logic [DIVD_W-1:0]     opos_ext, count;
  logic                  ahead, over;
  logic [RUN_W-1:0]      emit_n;
  logic                  cnt_end;
  logic [POS_W-1:0]      ipos_inc;

  assign ir_eff   = (in_rate_q == '0) ? RATE_W'(1) : in_rate_q;
  assign or_eff   = (out_rate_q == '0) ? RATE_W'(1) : out_rate_q;
  assign rates_eq = ir_eff == or_eff;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign ipos1     = {1'b0, in_pos_q} + (POS_W + 1)'(1);
  assign prod_full = DIVD_W'(ipos1) * DIVD_W'(or_eff);
  assign dividend  = prod_q + DIVD_W'(ir_eff) - DIVD_W'(1);

  assign opos_ext = DIVD_W'(out_pos_q);
  assign ahead    = quotient > opos_ext;
  assign count    = ahead ? (quotient - opos_ext) : '0;
  assign over     = count > DIVD_W'(MAX_RUN);
  assign emit_n   = over ? RUN_W'(MAX_RUN) : count[RUN_W-1:0];

  assign cnt_end  = cnt_q == (emit_q - RUN_W'(1));
  assign ipos_inc = in_pos_q + POS_W'(1);

  nsrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ir_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = rates_eq ? S_EMIT : S_MUL;
        end
      end
      S_MUL:    state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = (emit_n == '0) ? S_WRAP : S_EMIT;
      end
      S_EMIT: begin
        if (out_acc && cnt_end) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = !cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      S_DSTART: div_start   = 1'b1;
      S_EMIT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_rate_q  <= IN_RATE_RST;
      out_rate_q <= OUT_RATE_RST;
      in_pos_q   <= '0;
      out_pos_q  <= '0;
      opos_q     <= '0;
      emit_q     <= '0;
      cnt_q      <= '0;
      clip_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_IN_RATE: begin
            in_rate_q <= cfg_data_i;
            in_pos_q  <= '0;
            out_pos_q <= '0;
          end
          REG_OUT_RATE: out_rate_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_q  <= '0;
        emit_q <= RUN_W'(1);
        clip_q <= 1'b0;
        opos_q <= out_pos_q + POS_W'(1);
      end
      if (state_q == S_EVAL) begin
        emit_q <= emit_n;
        clip_q <= over;
        opos_q <= ahead ? quotient[POS_W-1:0] : out_pos_q;
      end
      if (out_acc) begin
        cnt_q <= cnt_q + RUN_W'(1);
      end
      if (state_q == S_WRAP) begin
        if (ipos_inc >= ir_eff) begin
          in_pos_q  <= ipos_inc - ir_eff;
          out_pos_q <= (opos_q >= or_eff) ? (opos_q - or_eff) : '0;
        end else begin
          in_pos_q  <= ipos_inc;
          out_pos_q <= opos_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_q <= in_frame_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_full;
    end
  end

  assign out_frame_o = frame_q;
  assign last_o      = cnt_end;
  assign clipped_o   = clip_q;

  `NSRC_ASSERT(a_ready_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while emitting")
  `NSRC_ASSERT(a_last_ends, clk_i, rst_ni, (out_acc && last_o) |=> !out_valid_o, "copy after last")
  `NSRC_ASSERT(a_run_cap, clk_i, rst_ni, out_valid_o |-> (emit_q != '0 && cnt_q < emit_q), "run overflow")
  `NSRC_ASSERT(a_clip_full, clk_i, rst_ni, (out_valid_o && clipped_o) |-> (emit_q == RUN_W'(MAX_RUN)), "clipped short run")

endmodule
